// File: hdl/vst_pkg.sv
// ----------------------------------------------------------------------------
// vst_pkg: shared types and constants for the vibration statistics block
// Widths, reset values, request and register codes, and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package vst_pkg;

  // Field widths
  localparam int unsigned DataW    = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned RankOutW = 6;

  // Default list depth
  localparam int unsigned TopKDef = 10;

  // Register reset values (0.1 and 0.5 in Q4.12) and count ceiling
  localparam logic [DataW-1:0] NoiseFloorRst = 16'd410;
  localparam logic [DataW-1:0] LevelRst      = 16'd2048;
  localparam logic [DataW-1:0] CountMax      = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_NOISE_FLOOR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL       = 2'd1;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // Controller to datapath
  typedef struct packed {
    logic sample_en;  // fold in the presented sample
    logic clear_en;   // reset statistics and list
    logic div_start;  // launch average divide
    logic rank_clr;   // restart rank counter
    logic step;       // rotate list by one and advance rank
  } vst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;   // average ready (one-cycle pulse)
    logic empty;      // nothing kept
    logic last_rank;  // current rank is the final result
    logic rot_done;   // list rotated back to its home position
  } vst_status_t;

endpackage

// File: hdl/vst_div.sv
// ----------------------------------------------------------------------------
// vst_div: restoring divider for the running average
// One quotient bit per cycle; the quotient is held until the next start.
// ----------------------------------------------------------------------------
module vst_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vst_pkg::SumW-1:0]    dividend_i,
  input  logic [vst_pkg::DataW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [vst_pkg::DataW-1:0]   quot_o
);
  import vst_pkg::*;

  localparam int unsigned CntW = $clog2(SumW);

  logic [SumW-1:0]  work_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DataW:0]   shifted;
  logic             fits;

  // Trial subtraction
  assign shifted = {rem_q, work_q[SumW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        work_q <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        work_q <= {work_q[SumW-2:0], fits};
        rem_q  <= fits ? DataW'(shifted - {1'b0, dvs_q}) : shifted[DataW-1:0];
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient never exceeds the field width: sum <= count * max sample
  assign quot_o = work_q[DataW-1:0];
  assign done_o = done_q;

endmodule

// File: hdl/vst_dp.sv
// ----------------------------------------------------------------------------
// vst_dp: statistics datapath
// Holds the config registers, running count/sum/peak/flag, the sorted
// top list as a row of cells, the rank counter and the average divider.
// ----------------------------------------------------------------------------
module vst_dp #(
  parameter int unsigned TopK = vst_pkg::TopKDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_i,
  input  logic [vst_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vst_pkg::DataW-1:0]     cfg_data_i,
  input  logic [vst_pkg::DataW-1:0]     sample_i,
  input  vst_pkg::vst_cmd_t             cmd_i,
  output vst_pkg::vst_status_t          sts_o,
  output logic [vst_pkg::RankOutW-1:0]  rank_o,
  output logic [vst_pkg::DataW-1:0]     top_value_o,
  output logic                          entry_valid_o,
  output logic [vst_pkg::DataW-1:0]     kept_count_o,
  output logic [vst_pkg::DataW-1:0]     average_o,
  output logic [vst_pkg::DataW-1:0]     peak_o,
  output logic                          above_level_o,
  output logic                          last_o
);
  import vst_pkg::*;

  localparam int unsigned RankW = $clog2(TopK + 1);

  logic [DataW-1:0] floor_q;
  logic [DataW-1:0] level_q;
  logic [DataW-1:0] count_q;
  logic [SumW-1:0]  sum_q;
  logic [DataW-1:0] peak_q;
  logic             flag_q;
  logic [DataW-1:0] list_q [TopK];
  logic [TopK-1:0]  fill_q;
  logic [TopK-1:0]  ge;
  logic [RankW-1:0] rank_q;
  logic [RankW-1:0] rank_next;
  logic [RankW-1:0] n_fill;
  logic             keep;
  logic             add_en;
  logic             empty;
  logic             div_done;
  logic [DataW-1:0] quot;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= NoiseFloorRst;
      level_q <= LevelRst;
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_NOISE_FLOOR: floor_q <= cfg_data_i;
        CFG_LEVEL:       level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Noise gate and count saturation
  assign keep   = cmd_i.sample_en && (sample_i >= floor_q);
  assign add_en = keep && (count_q != CountMax);

  // Running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      peak_q  <= '0;
      flag_q  <= 1'b1;
    end else if (cmd_i.clear_en) begin
      count_q <= '0;
      sum_q   <= '0;
      peak_q  <= '0;
      flag_q  <= 1'b1;
    end else if (keep) begin
      if (add_en) begin
        count_q <= count_q + 1'b1;
        sum_q   <= sum_q + SumW'(sample_i);
      end
      if (sample_i > peak_q) begin
        peak_q <= sample_i;
      end
      if (sample_i <= level_q) begin
        flag_q <= 1'b0;
      end
    end
  end

  // Top list cells: parallel compare picks the slot, lower entries shift down.
  // During a report the whole row rotates so rank k sits in cell 0.
  for (genvar g = 0; g < TopK; g++) begin : g_cell
    localparam int unsigned Prv = (g == 0) ? 0 : g - 1;
    localparam int unsigned Nxt = (g + 1) % TopK;

    logic [DataW-1:0] ins_val;

    assign ge[g]   = fill_q[g] && (list_q[g] >= sample_i);
    assign ins_val = ge[g] ? list_q[g] :
                     ((g == 0) || ge[Prv]) ? sample_i : list_q[Prv];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        list_q[g] <= '0;
        fill_q[g] <= 1'b0;
      end else if (cmd_i.clear_en) begin
        list_q[g] <= '0;
        fill_q[g] <= 1'b0;
      end else if (keep) begin
        list_q[g] <= ins_val;
        fill_q[g] <= (g == 0) ? 1'b1 : fill_q[Prv];
      end else if (cmd_i.step) begin
        list_q[g] <= list_q[Nxt];
      end
    end
  end

  // Rank counter
  assign rank_next = RankW'(rank_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else if (cmd_i.rank_clr) begin
      rank_q <= '0;
    end else if (cmd_i.step) begin
      rank_q <= rank_next;
    end
  end

  // Filled ranks: min(count, TopK)
  assign n_fill = (count_q >= DataW'(TopK)) ? RankW'(TopK) : count_q[RankW-1:0];
  assign empty  = (count_q == '0);

  // Average divider
  vst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Status
  assign sts_o.div_done  = div_done;
  assign sts_o.empty     = empty;
  assign sts_o.last_rank = empty || (rank_next == n_fill);
  assign sts_o.rot_done  = (rank_q == RankW'(TopK));

  // Result fields
  assign rank_o        = RankOutW'(rank_q);
  assign top_value_o   = list_q[0];
  assign entry_valid_o = !empty;
  assign kept_count_o  = count_q;
  assign average_o     = empty ? '0 : quot;
  assign peak_o        = peak_q;
  assign above_level_o = flag_q;
  assign last_o        = sts_o.last_rank;

endmodule

// File: hdl/vst_ctrl.sv
// ----------------------------------------------------------------------------
// vst_ctrl: request sequencer
// Decodes requests, runs the divide, paces report results and restores
// the list position afterwards.
// ----------------------------------------------------------------------------
module vst_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [vst_pkg::ReqW-1:0]    req_type_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output vst_pkg::vst_cmd_t           cmd_o,
  input  vst_pkg::vst_status_t        sts_i
);
  import vst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT,
    S_ROT
  } state_e;

  state_e state_q, state_d;
  req_e   req;

  assign req = req_e'(req_type_i);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (req)
            REQ_SAMPLE: cmd_o.sample_en = 1'b1;
            REQ_CLEAR:  cmd_o.clear_en  = 1'b1;
            REQ_REPORT: begin
              cmd_o.div_start = 1'b1;
              cmd_o.rank_clr  = 1'b1;
              state_d         = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (sts_i.empty) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
            if (sts_i.last_rank) begin
              state_d = S_ROT;
            end
          end
        end
      end
      S_ROT: begin
        if (sts_i.rot_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

// File: hdl/vibration_stats_top_k_top.sv
// ----------------------------------------------------------------------------
// vibration_stats_top_k_top: noise-gated vibration statistics with top-K list
// Input channel (in_valid_i/in_ready_o) carries a request code and a Q4.12
// sample. Sample requests below the noise floor are dropped; kept samples
// update count, sum, peak, the all-above flag and the sorted list. Sample and
// clear requests complete in the cycle they are taken, so one may be
// transferred every clock.
// A report request starts a bit-serial divide for the average, then
// presents one result per filled rank on out_valid_o/out_ready_i (or a single
// empty result), one per cycle while the receiver is ready; last_o marks the
// final one. The list is held as a row of cells and rotates one place per
// result; after the last result of a non-empty report it rotates TOP_K - n
// more places and checks that it is home before the next request is taken.
// Throughout a report, including any receiver stall, in_ready_o is low,
// and the result payload holds steady while the receiver stalls.
// The configuration channel is always ready: index 0 is the noise floor,
// index 1 the level threshold; other indexes are ignored.
// Reset clears the statistics and list and loads the register defaults.
// ----------------------------------------------------------------------------
module vibration_stats_top_k_top #(
  parameter int unsigned TopK = vst_pkg::TopKDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vst_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vst_pkg::DataW-1:0]     cfg_data_i,
  // Requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vst_pkg::ReqW-1:0]      req_type_i,
  input  logic [vst_pkg::DataW-1:0]     sample_i,
  // Results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vst_pkg::RankOutW-1:0]  rank_o,
  output logic [vst_pkg::DataW-1:0]     top_value_o,
  output logic                          entry_valid_o,
  output logic [vst_pkg::DataW-1:0]     kept_count_o,
  output logic [vst_pkg::DataW-1:0]     average_o,
  output logic [vst_pkg::DataW-1:0]     peak_o,
  output logic                          above_level_o,
  output logic                          last_o
);
  import vst_pkg::*;

  vst_cmd_t    cmd;
  vst_status_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  vst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vst_dp #(
    .TopK (TopK)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rank_o        (rank_o),
    .top_value_o   (top_value_o),
    .entry_valid_o (entry_valid_o),
    .kept_count_o  (kept_count_o),
    .average_o     (average_o),
    .peak_o        (peak_o),
    .above_level_o (above_level_o),
    .last_o        (last_o)
  );

endmodule

// File: dv/vst_stats_checker.sv
// ----------------------------------------------------------------------------
// vst_stats_checker: result predictor and scoreboard for vibration statistics
// Watches the configuration, request and result channels. Keeps its own copy
// of the registers, running statistics and ranked list, queues the lines each
// report should produce and compares every transferred result field by field.
// ----------------------------------------------------------------------------
module vst_stats_checker #(
  parameter int unsigned TopK = vst_pkg::TopKDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [vst_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vst_pkg::DataW-1:0]     cfg_data_i,
  // Request channel
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [vst_pkg::ReqW-1:0]      req_type_i,
  input  logic [vst_pkg::DataW-1:0]     sample_i,
  // Result channel
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [vst_pkg::RankOutW-1:0]  rank_i,
  input  logic [vst_pkg::DataW-1:0]     top_value_i,
  input  logic                          entry_valid_i,
  input  logic [vst_pkg::DataW-1:0]     kept_count_i,
  input  logic [vst_pkg::DataW-1:0]     average_i,
  input  logic [vst_pkg::DataW-1:0]     peak_i,
  input  logic                          above_level_i,
  input  logic                          last_i,
  // Status towards the testbench
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   lines_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vst_pkg::*;

  // One report line as the block should present it
  typedef struct packed {
    logic [RankOutW-1:0] rank;
    logic [DataW-1:0]    value;
    logic                entry_valid;
    logic [DataW-1:0]    kept;
    logic [DataW-1:0]    avg;
    logic [DataW-1:0]    peak;
    logic                above_level;
    logic                last;
  } stat_line_t;

  // Predicted registers and statistics
  logic [DataW-1:0] floor_q;
  logic [DataW-1:0] level_q;
  logic [DataW-1:0] kept_q;
  logic [SumW-1:0]  sum_q;
  logic [DataW-1:0] peak_q;
  logic             above_q;
  logic [DataW-1:0] ranked_q [TopK];

  stat_line_t  expected_lines[$];
  int unsigned mismatches;
  int unsigned lines_checked;

  assign mismatch_count_o = mismatches;
  assign lines_checked_o  = lines_checked;

  // One printed line and a count per mismatch
  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("%0t ns: result mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_mismatch(what, got, want);
    end
  endtask

  function automatic int unsigned filled_ranks();
    return (kept_q < TopK) ? int'(kept_q) : TopK;
  endfunction

  task automatic clear_stats();
    kept_q  = '0;
    sum_q   = '0;
    peak_q  = '0;
    above_q = 1'b1;
    foreach (ranked_q[i]) ranked_q[i] = '0;
  endtask

  // Descending insert; equal values land below those already listed
  task automatic insert_ranked(input logic [DataW-1:0] v);
    int n;
    int pos;
    n = filled_ranks();
    if (n == TopK && v <= ranked_q[TopK-1]) return;
    pos = 0;
    while (pos < n && ranked_q[pos] >= v) pos++;
    if (pos >= TopK) return;
    for (int i = (n < TopK) ? n : TopK - 1; i > pos; i--) begin
      ranked_q[i] = ranked_q[i-1];
    end
    ranked_q[pos] = v;
  endtask

  // Kept samples update list (with the old count), count, sum, peak, flag
  task automatic fold_sample(input logic [DataW-1:0] v);
    if (v < floor_q) return;
    insert_ranked(v);
    if (kept_q != CountMax) begin
      kept_q++;
      sum_q += SumW'(v);
    end
    if (v > peak_q) peak_q = v;
    if (v <= level_q) above_q = 1'b0;
  endtask

  // Lines a report yields: one per filled rank, or a single empty line
  task automatic predict_report();
    stat_line_t      line;
    logic [SumW-1:0] quotient;
    int unsigned     n;
    quotient         = (kept_q != 0) ? sum_q / SumW'(kept_q) : '0;
    n                = filled_ranks();
    line.kept        = kept_q;
    line.avg         = quotient[DataW-1:0];
    line.peak        = peak_q;
    line.above_level = above_q;
    if (n == 0) begin
      line.rank        = '0;
      line.value       = '0;
      line.entry_valid = 1'b0;
      line.last        = 1'b1;
      expected_lines.push_back(line);
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        line.rank        = RankOutW'(k);
        line.value       = ranked_q[k];
        line.entry_valid = 1'b1;
        line.last        = (k + 1 == n);
        expected_lines.push_back(line);
      end
    end
  endtask

  // Compare a transferred result against the oldest expectation
  task automatic compare_line();
    stat_line_t want;
    if (expected_lines.size() == 0) begin
      log_mismatch("unexpected result (rank)", 32'(rank_i), 32'hFFFF_FFFF);
      return;
    end
    want = expected_lines.pop_front();
    lines_checked++;
    check_field("rank",        32'(rank_i),        32'(want.rank));
    check_field("top_value",   32'(top_value_i),   32'(want.value));
    check_field("entry_valid", 32'(entry_valid_i), 32'(want.entry_valid));
    check_field("kept_count",  32'(kept_count_i),  32'(want.kept));
    check_field("average",     32'(average_i),     32'(want.avg));
    check_field("peak",        32'(peak_i),        32'(want.peak));
    check_field("above_level", 32'(above_level_i), 32'(want.above_level));
    check_field("last",        32'(last_i),        32'(want.last));
  endtask

  // Channel monitor: every transfer is seen at the edge that takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q = NoiseFloorRst;
      level_q = LevelRst;
      clear_stats();
      expected_lines.delete();
      mismatches    = 0;
      lines_checked = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NOISE_FLOOR: floor_q = cfg_data_i;
          CFG_LEVEL:       level_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (req_type_i)
          REQ_SAMPLE: fold_sample(sample_i);
          REQ_REPORT: predict_report();
          REQ_CLEAR:  clear_stats();
          default: ;  // spare code leaves everything alone
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        compare_line();
      end
      pending_o <= expected_lines.size();
    end
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for vibration_stats_top_k_top
// Drives requests with random gaps and register writes back to back, stalls
// the result side at random (including one long hold that backs the block
// up), runs a directed opening and random phases over several register
// settings. Checking is done by vst_stats_checker alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vst_pkg::*;

  localparam int unsigned TopK         = TopKDef;
  localparam int unsigned SettleCycles = TopK + 12;  // rotation tail and check cycle
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned HoldCycles   = 300;
  localparam logic [ReqW-1:0]    ReqSpare = 2'd3;     // unused request code
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;     // unmapped register index

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [DataW-1:0]    cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [ReqW-1:0]     req_type    = REQ_SAMPLE;
  logic [DataW-1:0]    sample      = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [RankOutW-1:0] rank;
  logic [DataW-1:0]    top_value;
  logic                entry_valid;
  logic [DataW-1:0]    kept_count;
  logic [DataW-1:0]    average;
  logic [DataW-1:0]    peak;
  logic                above_level;
  logic                last;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned lines_checked;

  logic [DataW-1:0] cur_floor = NoiseFloorRst;
  logic [DataW-1:0] cur_level = LevelRst;
  int unsigned      requests_sent = 0;
  int unsigned      reports_sent  = 0;
  int unsigned      hold_asks     = 0;
  int unsigned      hold_done     = 0;
  int unsigned      steady_items  = 0;
  bit               sender_steady = 1'b0;

  wire any_transfer = (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
                      (out_valid && out_ready);

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  vibration_stats_top_k_top #(.TopK(TopK)) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .sample_i      (sample),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .rank_o        (rank),
    .top_value_o   (top_value),
    .entry_valid_o (entry_valid),
    .kept_count_o  (kept_count),
    .average_o     (average),
    .peak_o        (peak),
    .above_level_o (above_level),
    .last_o        (last)
  );

  vst_stats_checker #(.TopK(TopK)) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .req_type_i       (req_type),
    .sample_i         (sample),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .rank_i           (rank),
    .top_value_i      (top_value),
    .entry_valid_i    (entry_valid),
    .kept_count_i     (kept_count),
    .average_i        (average),
    .peak_i           (peak),
    .above_level_i    (above_level),
    .last_i           (last),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .lines_checked_o  (lines_checked)
  );

  // Sender gaps: runs with no idling, otherwise mostly short with a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_items == 0) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      steady_items  = $urandom_range(10, 40);
    end
    steady_items--;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Amplitudes clustered round the floor, the level and the field extremes
  function automatic logic [DataW-1:0] pick_amplitude();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 20)      v = int'(cur_floor) + $urandom_range(0, 4) - 2;
    else if (r < 35) v = int'(cur_level) + $urandom_range(0, 4) - 2;
    else if (r < 45) v = ($urandom_range(0, 1) == 1) ? 65535 - $urandom_range(0, 1)
                                                     : $urandom_range(0, 1);
    else             v = $urandom_range(0, 65535);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DataW'(v);
  endfunction

  // Offer one request after a gap and hold it until transferred
  task automatic send_request(input logic [ReqW-1:0] code,
                              input logic [DataW-1:0] value,
                              input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= code;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (code == REQ_REPORT) reports_sent++;
  endtask

  // Stop offering, wait for every expected line, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write both registers back to back, optionally poking the spare index too
  task automatic configure(input logic [DataW-1:0] floor_val,
                           input logic [DataW-1:0] level_val,
                           input bit poke_spare);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NOISE_FLOOR;
    cfg_data  <= floor_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_LEVEL;
    cfg_data  <= level_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CfgSpare;
      cfg_data  <= DataW'($urandom_range(0, 65535));
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_floor = floor_val;
    cur_level = level_val;
  endtask

  // Random mix: mostly samples, some reports, occasional clears and spares
  task automatic run_random(input int unsigned count);
    int unsigned r;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80)      send_request(REQ_SAMPLE, pick_amplitude(), pick_gap());
      else if (r < 92) send_request(REQ_REPORT, pick_amplitude(), pick_gap());
      else if (r < 97) send_request(REQ_CLEAR, pick_amplitude(), pick_gap());
      else             send_request(ReqSpare, pick_amplitude(), pick_gap());
    end
  endtask

  // Result side: random stalls, steady stretches, and the requested long hold
  initial begin
    int unsigned stall_left;
    int unsigned steady_left;
    int unsigned r;
    bit          steady;
    stall_left  = 0;
    steady_left = 0;
    steady      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done++;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        if (steady_left == 0) begin
          steady      = ($urandom_range(0, 3) == 0);
          steady_left = $urandom_range(20, 80);
        end
        steady_left--;
        r = $urandom_range(0, 99);
        if (steady || r < 75) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (any_transfer) idle_cycles = 0;
      else              idle_cycles++;
    end
    $display("vibration_stats_top_k_top verification failed");
    $finish;
  end

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at reset settings: empty report, floor and level edges
    send_request(REQ_REPORT, 16'hFFFF, 0);
    send_request(REQ_SAMPLE, 16'd0, 0);
    send_request(REQ_SAMPLE, NoiseFloorRst - 16'd1, 1);
    send_request(REQ_SAMPLE, NoiseFloorRst, 0);
    send_request(REQ_SAMPLE, LevelRst, 0);
    send_request(REQ_SAMPLE, 16'hFFFF, 2);
    send_request(REQ_REPORT, 16'd0, 0);
    send_request(REQ_CLEAR, 16'hFFFF, 0);
    send_request(REQ_REPORT, 16'd0, 0);
    send_request(ReqSpare, 16'hFFFF, 0);
    send_request(REQ_REPORT, 16'd0, 0);
    // Fill the list past its depth, all above level, with ties
    send_request(REQ_CLEAR, 16'd0, 0);
    send_request(REQ_SAMPLE, 16'd3000, 0);
    send_request(REQ_SAMPLE, 16'd5000, 0);
    send_request(REQ_SAMPLE, 16'd5000, 0);
    send_request(REQ_SAMPLE, 16'hFFFF, 0);
    send_request(REQ_SAMPLE, 16'd2049, 0);
    send_request(REQ_SAMPLE, 16'd4000, 0);
    send_request(REQ_SAMPLE, 16'd3000, 0);
    send_request(REQ_SAMPLE, 16'd3000, 0);
    send_request(REQ_SAMPLE, 16'd9000, 0);
    send_request(REQ_SAMPLE, 16'd2049, 0);
    send_request(REQ_SAMPLE, 16'd2049, 0);  // ties the smallest: stays out
    send_request(REQ_SAMPLE, 16'd7000, 0);  // displaces the smallest
    send_request(REQ_REPORT, 16'd0, 0);
    settle();

    // Lowest register settings: everything kept, level never exceeded by zero
    configure(16'h0000, 16'h0000, 1'b1);
    run_random(110);
    settle();

    // Highest register settings: only full-scale samples kept, flag drops
    configure(16'hFFFF, 16'hFFFF, 1'b0);
    run_random(60);
    settle();

    // Mid settings with a long receiver hold while requests keep coming
    configure(DataW'($urandom_range(0, 3000)), DataW'($urandom_range(1000, 8000)), 1'b0);
    for (int i = 0; i < 12; i++) send_request(REQ_SAMPLE, pick_amplitude(), 0);
    hold_asks++;
    send_request(REQ_REPORT, 16'd0, 0);
    for (int i = 0; i < 8; i++) send_request(REQ_SAMPLE, pick_amplitude(), 0);
    run_random(110);
    settle();

    // Back to reset values, then random content
    configure(NoiseFloorRst, LevelRst, 1'b1);
    run_random(100);
    settle();

    $display("Summary: %0d requests (%0d reports) sent, %0d result lines checked.",
             requests_sent, reports_sent, lines_checked);
    $display("Summary: register extremes, spare codes and a %0d-cycle result hold.",
             HoldCycles);
    if (mismatch_count == 0 && pending == 0) begin
      $display("vibration_stats_top_k_top verification clean");
    end else begin
      $display("vibration_stats_top_k_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/vst_pkg.sv
hdl/vst_div.sv
hdl/vst_dp.sv
hdl/vst_ctrl.sv
hdl/vibration_stats_top_k_top.sv
dv/vst_stats_checker.sv
dv/testbench.sv
